// ===== sv/fcvs_pkg.sv =====
// shared constants, codes and types of the fixed capacity value set
package fcvs_pkg;

	localparam int CAPACITY_MAX = 32;
	localparam int VALUE_WIDTH  = 32;

	localparam int IDX_W = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
	localparam int CNT_W = $clog2(CAPACITY_MAX + 1);

	// fixed field widths of the stream payload
	localparam int FUNC_W   = 2;
	localparam int IN_VAL_W = 32;
	localparam int POS_W    = 5;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 6;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;

	// operation codes
	localparam logic [FUNC_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] OP_ADD    = 2'd1;
	localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_DUP    = 2'd2;
	localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

	// per-cell control from the sequencer
	typedef struct packed {
		logic cmp_en;
		logic in_use;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== sv/fcvs_cell.sv =====
// one storage cell of the value chain: holds an entry, compares, shifts down
module fcvs_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fcvs_pkg::cell_ctl_t                   ctl,
	input  logic [fcvs_pkg::VALUE_WIDTH-1:0]      key,
	input  logic [fcvs_pkg::VALUE_WIDTH-1:0]      next_value,
	output logic [fcvs_pkg::VALUE_WIDTH-1:0]      value,
	output logic                                  hit
);

	logic [fcvs_pkg::VALUE_WIDTH-1:0] value_q;
	logic                             hit_q;

	// entry storage: load from the broadcast key or take the upper neighbor
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= key;
		end else if (ctl.shift) begin
			value_q <= next_value;
		end
	end

	// registered match against the broadcast key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			hit_q <= ctl.in_use && (value_q == key);
		end
	end

	assign value = value_q;
	assign hit   = hit_q;

endmodule

// ===== sv/fcvs_enc.sv =====
// folds the one-hot-or-zero match vector into a found flag and a position
module fcvs_enc (
	input  logic [fcvs_pkg::CAPACITY_MAX-1:0] hits,
	output logic                              found,
	output logic [fcvs_pkg::IDX_W-1:0]        pos
);

	// stored values are distinct, so at most one bit is set and an or suffices
	always_comb begin
		pos = '0;
		for (int i = 0; i < fcvs_pkg::CAPACITY_MAX; i++) begin
			if (hits[i]) begin
				pos = pos | fcvs_pkg::IDX_W'(i);
			end
		end
		found = |hits;
	end

endmodule

// ===== sv/fixed_capacity_value_set_unit.sv =====
// top level of the fixed capacity value set: sequencer, cell chain, result register
//
// channel  dir  fields (tdata from bit 0 up)
// s_*      in   func[1:0], value[33:2], zero pad [39:34]
// m_*      out  found[0], position[5:1], status[7:6], count_after[13:8], zero pad [15:14]
//
// each operation runs through four steps: accept, compare in every cell, resolve
// the match position, then update the cells and load the result register.
// the match resolve is an or over all cells, kept apart from the shift so
// each cell only compares its own index against a registered position.
// reset clears the count, sequencer and result valid; entries are untouched.
// a stalled result holds the update step until the result register frees.
module fixed_capacity_value_set_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fcvs_pkg::IN_DATA_W-1:0]    s_tdata,  // func, value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fcvs_pkg::OUT_DATA_W-1:0]   m_tdata   // found, position, status, count_after
);

	localparam int N = fcvs_pkg::CAPACITY_MAX;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_MATCH   = 4'b0010,
		S_RESOLVE = 4'b0100,
		S_APPLY   = 4'b1000
	} state_t;

	state_t                             state_q;
	logic [fcvs_pkg::FUNC_W-1:0]        func_q;
	logic [fcvs_pkg::VALUE_WIDTH-1:0]   key_q;
	logic [fcvs_pkg::CNT_W-1:0]         count_q;
	logic                               found_q;
	logic [fcvs_pkg::IDX_W-1:0]         pos_q;
	logic [fcvs_pkg::STAT_W-1:0]        status_q;
	logic                               do_add_q;
	logic                               do_rem_q;

	logic                               out_valid_q;
	logic                               out_found_q;
	logic [fcvs_pkg::POS_W-1:0]         out_pos_q;
	logic [fcvs_pkg::STAT_W-1:0]        out_status_q;
	logic [fcvs_pkg::COUNT_W-1:0]       out_count_q;

	fcvs_pkg::cell_ctl_t                ctl [N];
	logic [fcvs_pkg::VALUE_WIDTH-1:0]   cell_value [N];
	logic [fcvs_pkg::VALUE_WIDTH-1:0]   cell_next [N];
	logic [N-1:0]                       hits;
	logic                               enc_found;
	logic [fcvs_pkg::IDX_W-1:0]         enc_pos;
	logic                               full;
	logic                               commit;
	logic [fcvs_pkg::CNT_W-1:0]         count_next;
	logic [fcvs_pkg::STAT_W-1:0]        status_next;
	logic                               do_add_next;
	logic                               do_rem_next;

	assign s_tready = (state_q == S_IDLE);
	assign full     = (count_q == fcvs_pkg::CNT_W'(N));
	assign commit   = (state_q == S_APPLY) && (!out_valid_q || m_tready);

	// count after this operation
	always_comb begin
		count_next = count_q;
		if (do_add_q) begin
			count_next = count_q + fcvs_pkg::CNT_W'(1);
		end else if (do_rem_q) begin
			count_next = count_q - fcvs_pkg::CNT_W'(1);
		end
	end

	// cell controls: compare in match step, load or shift in the commit cycle
	always_comb begin
		for (int i = 0; i < N; i++) begin
			ctl[i].cmp_en = (state_q == S_MATCH);
			ctl[i].in_use = (fcvs_pkg::CNT_W'(i) < count_q);
			ctl[i].load   = commit && do_add_q && (fcvs_pkg::CNT_W'(i) == count_q);
			ctl[i].shift  = commit && do_rem_q && (fcvs_pkg::IDX_W'(i) >= pos_q)
			                && (i < N - 1);
		end
	end

	// neighbor links down the chain; the top cell never shifts
	always_comb begin
		for (int i = 0; i < N - 1; i++) begin
			cell_next[i] = cell_value[i+1];
		end
		cell_next[N-1] = cell_value[N-1];
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		fcvs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[g]),
			.key        (key_q),
			.next_value (cell_next[g]),
			.value      (cell_value[g]),
			.hit        (hits[g])
		);
	end

	fcvs_enc u_enc (
		.hits  (hits),
		.found (enc_found),
		.pos   (enc_pos)
	);

	// operand capture on input transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tdata[fcvs_pkg::FUNC_W-1:0];
			key_q  <= fcvs_pkg::VALUE_WIDTH'(
				s_tdata[fcvs_pkg::FUNC_W +: fcvs_pkg::IN_VAL_W]);
		end
	end

	// operation decision from the match result
	always_comb begin
		status_next = fcvs_pkg::ST_OK;
		do_add_next = 1'b0;
		do_rem_next = 1'b0;
		case (func_q)
			fcvs_pkg::OP_ADD: begin
				if (full) begin
					status_next = fcvs_pkg::ST_FULL;
				end else if (enc_found) begin
					status_next = fcvs_pkg::ST_DUP;
				end else begin
					do_add_next = 1'b1;
				end
			end
			fcvs_pkg::OP_REMOVE: begin
				if (!enc_found) begin
					status_next = fcvs_pkg::ST_ABSENT;
				end else begin
					do_rem_next = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// resolve step: register match result and operation decision
	always_ff @(posedge clk) begin
		if (state_q == S_RESOLVE) begin
			found_q  <= enc_found;
			pos_q    <= enc_pos;
			status_q <= status_next;
			do_add_q <= do_add_next;
			do_rem_q <= do_rem_next;
		end
	end

	// sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH:   state_q <= S_RESOLVE;
				S_RESOLVE: state_q <= S_APPLY;
				S_APPLY: begin
					if (commit) begin
						count_q <= count_next;
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_found_q  <= found_q;
			out_pos_q    <= found_q ? fcvs_pkg::POS_W'(pos_q) : '0;
			out_status_q <= status_q;
			out_count_q  <= fcvs_pkg::COUNT_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_count_q, out_status_q, out_pos_q, out_found_q};

endmodule
